[hw/rtl/mssc_pkg.sv]
// Package for the motor soft-start core: widths, reset values, register
// indexes and request codes.
// No dependencies; compile before the interfaces and the core.
package mssc_pkg;

   localparam int ADC_BITS_DEFAULT = 10;
   localparam int PWM_BITS_DEFAULT = 8;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int INCIDENT_BITS  = 8;

   localparam logic [INCIDENT_BITS-1:0] MAX_INCIDENTS_RESET = 8'd10;
   localparam logic [7:0]               SPEED_CAP_RESET     = 8'd249;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CURRENT_LIMIT = 2'd0,
      CSR_MAX_INCIDENTS = 2'd1,
      CSR_SPEED_CAP     = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_DRIVE  = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_code_type;

endpackage

[hw/rtl/mssc_if.sv]
// Handshake interfaces for the motor soft-start core: request, response
// and register-write channels.
// Depends on mssc_pkg.
interface mssc_req_if #(
   parameter int ADC_BITS = mssc_pkg::ADC_BITS_DEFAULT,
   parameter int PWM_BITS = mssc_pkg::PWM_BITS_DEFAULT
);
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic signed [PWM_BITS:0]   left_speed;
   logic signed [PWM_BITS:0]   right_speed;
   logic        [ADC_BITS-1:0] current_a;
   logic        [ADC_BITS-1:0] current_b;

   modport source (output valid, req_type, left_speed, right_speed, current_a, current_b,
                   input ready);
   modport sink (input valid, req_type, left_speed, right_speed, current_a, current_b,
                 output ready);
endinterface

interface mssc_rsp_if #(
   parameter int ADC_BITS = mssc_pkg::ADC_BITS_DEFAULT,
   parameter int PWM_BITS = mssc_pkg::PWM_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [PWM_BITS-1:0] pwm_left;
   logic [PWM_BITS-1:0] pwm_right;
   logic                left_reverse;
   logic                right_reverse;
   logic [ADC_BITS-1:0] peak_a;
   logic [ADC_BITS-1:0] peak_b;
   logic                ramping;

   modport source (output valid, pwm_left, pwm_right, left_reverse, right_reverse,
                   peak_a, peak_b, ramping, input ready);
   modport sink (input valid, pwm_left, pwm_right, left_reverse, right_reverse,
                 peak_a, peak_b, ramping, output ready);
endinterface

interface mssc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [mssc_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [mssc_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/motor_soft_start_current_limit_core.sv]
// Two-motor soft-start ramp with current limiting. Every request word yields
// one registered response word; a new word can be taken in every cycle while
// the skid register is empty, the whole state update being one pass of
// compares and increments between the state registers. A two-entry output
// (response register plus skid register) keeps requests flowing for one more
// word after the response side stalls. A drive word sets targets, reverse
// bits and clears the ramp; a sample word steps the ramp up, or down with an
// incident, while ramping. Register writes are always accepted.
module motor_soft_start_current_limit_core #(
   parameter int ADC_BITS = mssc_pkg::ADC_BITS_DEFAULT,
   parameter int PWM_BITS = mssc_pkg::PWM_BITS_DEFAULT
) (
   input logic   clock,
   input logic   reset,
   mssc_req_if.sink   req_bus,
   mssc_rsp_if.source rsp_bus,
   mssc_csr_if.sink   csr_bus
);

   localparam int IB       = mssc_pkg::INCIDENT_BITS;
   localparam int RSP_BITS = 2 * PWM_BITS + 2 * ADC_BITS + 3;
   localparam logic [ADC_BITS-1:0] LIMIT_RESET = ADC_BITS'(1) << (ADC_BITS - 1);

   logic [ADC_BITS-1:0] current_limit_ff;
   logic [IB-1:0]       max_incidents_ff;
   logic [PWM_BITS-1:0] speed_cap_ff;

   logic [PWM_BITS-1:0] target_left_ff,  target_left_in;
   logic [PWM_BITS-1:0] target_right_ff, target_right_in;
   logic [PWM_BITS:0]   ramp_level_ff,   ramp_level_in;
   logic [IB-1:0]       incident_ff,     incident_in;
   logic [PWM_BITS-1:0] level_left_ff,   level_left_in;
   logic [PWM_BITS-1:0] level_right_ff,  level_right_in;
   logic [ADC_BITS-1:0] peak_left_ff,    peak_left_in;
   logic [ADC_BITS-1:0] peak_right_ff,   peak_right_in;
   logic [1:0]          reverse_ff,      reverse_in;
   logic                active_ff,       active_in;

   logic                out_valid_ff,  out_valid_in;
   logic [RSP_BITS-1:0] out_data_ff,   out_data_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [RSP_BITS-1:0] skid_data_ff,  skid_data_in;

   logic                req_accept;
   logic [RSP_BITS-1:0] new_word;
   logic [PWM_BITS:0]   left_mag;
   logic [PWM_BITS:0]   right_mag;
   logic [PWM_BITS:0]   cap_ext;
   logic                left_pos, left_neg, right_pos, right_neg;
   logic                below_limit;

   assign req_bus.ready = !skid_valid_ff;
   assign csr_bus.ready = 1'b1;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         current_limit_ff <= LIMIT_RESET;
         max_incidents_ff <= mssc_pkg::MAX_INCIDENTS_RESET;
         speed_cap_ff     <= PWM_BITS'(mssc_pkg::SPEED_CAP_RESET);
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            mssc_pkg::CSR_CURRENT_LIMIT: current_limit_ff <= csr_bus.data[ADC_BITS-1:0];
            mssc_pkg::CSR_MAX_INCIDENTS: max_incidents_ff <= csr_bus.data[IB-1:0];
            mssc_pkg::CSR_SPEED_CAP:     speed_cap_ff     <= PWM_BITS'(csr_bus.data[7:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      left_mag  = req_bus.left_speed[PWM_BITS] ?
                  (~req_bus.left_speed + 1'b1) : req_bus.left_speed;
      right_mag = req_bus.right_speed[PWM_BITS] ?
                  (~req_bus.right_speed + 1'b1) : req_bus.right_speed;
      cap_ext   = {1'b0, speed_cap_ff};
      left_neg  = req_bus.left_speed[PWM_BITS];
      right_neg = req_bus.right_speed[PWM_BITS];
      left_pos  = !left_neg && (req_bus.left_speed != '0);
      right_pos = !right_neg && (req_bus.right_speed != '0);
      below_limit = (req_bus.current_a < current_limit_ff) &&
                    (req_bus.current_b < current_limit_ff);

      target_left_in  = target_left_ff;
      target_right_in = target_right_ff;
      ramp_level_in   = ramp_level_ff;
      incident_in     = incident_ff;
      level_left_in   = level_left_ff;
      level_right_in  = level_right_ff;
      peak_left_in    = peak_left_ff;
      peak_right_in   = peak_right_ff;
      reverse_in      = reverse_ff;
      active_in       = active_ff;

      if (req_bus.req_type == mssc_pkg::REQ_DRIVE) begin
         target_left_in  = (left_mag > cap_ext) ? speed_cap_ff : left_mag[PWM_BITS-1:0];
         target_right_in = (right_mag > cap_ext) ? speed_cap_ff : right_mag[PWM_BITS-1:0];
         if (left_pos && right_pos) begin
            reverse_in = 2'b00;
         end else if (left_neg && right_neg) begin
            reverse_in = 2'b11;
         end else if (left_neg && right_pos) begin
            reverse_in = 2'b01;
         end else begin
            reverse_in = 2'b10;
         end
         ramp_level_in  = '0;
         incident_in    = '0;
         level_left_in  = '0;
         level_right_in = '0;
         peak_left_in   = '0;
         peak_right_in  = '0;
         active_in = (max_incidents_ff != '0) &&
                     !(target_left_in == '0 && target_right_in == '0);
      end else if (active_ff) begin
         if (req_bus.current_a > peak_left_ff) begin
            peak_left_in = req_bus.current_a;
         end
         if (req_bus.current_b > peak_right_ff) begin
            peak_right_in = req_bus.current_b;
         end
         if (below_limit) begin
            if (ramp_level_ff != '1) begin
               ramp_level_in = ramp_level_ff + 1'b1;
            end
         end else begin
            if (ramp_level_ff != '0) begin
               ramp_level_in = ramp_level_ff - 1'b1;
            end
            if (incident_ff != '1) begin
               incident_in = incident_ff + 1'b1;
            end
         end
         level_left_in  = (ramp_level_in < {1'b0, target_left_ff}) ?
                          ramp_level_in[PWM_BITS-1:0] : target_left_ff;
         level_right_in = (ramp_level_in < {1'b0, target_right_ff}) ?
                          ramp_level_in[PWM_BITS-1:0] : target_right_ff;
         active_in = (incident_in < max_incidents_ff) &&
                     !(level_left_in == target_left_ff && level_right_in == target_right_ff);
      end

      new_word = {level_left_in, level_right_in, reverse_in[0], reverse_in[1],
                  peak_left_in, peak_right_in, active_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_left_ff  <= '0;
         target_right_ff <= '0;
         ramp_level_ff   <= '0;
         incident_ff     <= '0;
         level_left_ff   <= '0;
         level_right_ff  <= '0;
         peak_left_ff    <= '0;
         peak_right_ff   <= '0;
         reverse_ff      <= '0;
         active_ff       <= 1'b0;
      end else if (req_accept) begin
         target_left_ff  <= target_left_in;
         target_right_ff <= target_right_in;
         ramp_level_ff   <= ramp_level_in;
         incident_ff     <= incident_in;
         level_left_ff   <= level_left_in;
         level_right_ff  <= level_right_in;
         peak_left_ff    <= peak_left_in;
         peak_right_ff   <= peak_right_in;
         reverse_ff      <= reverse_in;
         active_ff       <= active_in;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_bus.ready) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_accept;
            out_data_in  = new_word;
         end
      end else if (out_valid_ff) begin
         if (req_accept) begin
            skid_valid_in = 1'b1;
            skid_data_in  = new_word;
         end
      end else if (req_accept) begin
         out_valid_in = 1'b1;
         out_data_in  = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign {rsp_bus.pwm_left, rsp_bus.pwm_right, rsp_bus.left_reverse, rsp_bus.right_reverse,
           rsp_bus.peak_a, rsp_bus.peak_b, rsp_bus.ramping} = out_data_ff;

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without a response word");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_bus.req_type == mssc_pkg::REQ_SAMPLE && !active_ff)
      |=> ($stable(ramp_level_ff) && $stable(incident_ff)))
      else $error("sample while idle changed the ramp");

   a_drive_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_bus.req_type == mssc_pkg::REQ_DRIVE)
      |=> (incident_ff == '0 && ramp_level_ff == '0))
      else $error("drive word did not clear the ramp");

   a_level_bounded: assert property (@(posedge clock) disable iff (reset)
      (level_left_ff <= target_left_ff) && (level_right_ff <= target_right_ff))
      else $error("motor level above its target");
`endif

endmodule
